// ===== rtl/core/rmmst_pkg.sv =====
// Shared types and constants of the range min/max spread tree.
package rmmst_pkg;

  // Fixed field widths of the item and result channels.
  localparam int unsigned IdxW   = 16;
  localparam int unsigned ValW   = 20;
  localparam int unsigned CountW = 17;

  // Element count after reset.
  localparam logic [CountW-1:0] CountReset = 17'h1_0000;

  // Operation codes carried in the func field.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Status codes of a result item.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    logic            func;
    logic [IdxW-1:0] write_index;
    logic [ValW-1:0] write_value;
    logic [IdxW-1:0] left_bound;
    logic [IdxW-1:0] right_bound;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] spread;
    logic            status;
  } out_item_t;

endpackage

// ===== rtl/core/rmmst_chan_if.sv =====
// Valid/ready channel interface carrying one payload item per handshake.
interface rmmst_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/core/range_min_max_spread_tree_unit.sv =====
// Range spread unit: min and max segment trees kept in one node memory.
// Write item: the leaf is written first, then one tree level is written per cycle up to the root.
// Query item: a walk over the tree levels from the leaves towards the root; a bad range skips the walk.
// The walk is paced by the single read port of the node memory; one item at a time.
// After reset a clearing pass writes all 2*MAX_ELEMENTS nodes before the first item is taken;
// configuration writes are taken throughout.
module range_min_max_spread_tree_unit #(
  parameter int unsigned MAX_ELEMENTS = 65536,
  parameter int unsigned VALUE_BITS   = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rmmst_chan_if.sink    in_i,
  rmmst_chan_if.source  out_o,
  rmmst_chan_if.sink    cfg_i
);

  localparam int unsigned Depth = 2 * MAX_ELEMENTS;
  localparam int unsigned NodeW = $clog2(Depth);
  localparam int unsigned PtrW  = NodeW + 1;
  localparam int unsigned WordW = 2 * VALUE_BITS;

  localparam logic [NodeW-1:0]      LastNode = NodeW'(Depth - 1);
  localparam logic [NodeW-1:0]      RootNode = NodeW'(1);
  localparam logic [NodeW-1:0]      LeafNode = NodeW'(MAX_ELEMENTS);
  localparam logic [PtrW-1:0]       LeafPtr  = PtrW'(MAX_ELEMENTS);
  localparam logic [20:0]           MaxElem  = 21'(MAX_ELEMENTS);
  localparam logic [VALUE_BITS-1:0] MinIdent = '1;
  localparam logic [VALUE_BITS-1:0] MaxIdent = '0;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WLEAF = 6'b000100,
    S_WUP   = 6'b001000,
    S_QWALK = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic [NodeW-1:0]           node_q, node_d;
  logic [PtrW-1:0]            lo_q, lo_d;
  logic [PtrW-1:0]            hi_q, hi_d;
  logic [VALUE_BITS-1:0]      cur_min_q, cur_min_d;
  logic [VALUE_BITS-1:0]      cur_max_q, cur_max_d;
  logic                       pend_q, pend_d;
  logic                       err_q, err_d;
  rmmst_pkg::count_t          count_q;
  logic                       out_valid_q, out_valid_d;
  logic [rmmst_pkg::ValW-1:0] out_spread_q, out_spread_d;
  logic                       out_status_q, out_status_d;

  // Node memory: each word holds {minimum, maximum} of one tree node.
  logic [WordW-1:0]           tree_mem [Depth];
  logic [WordW-1:0]           rdata_q;
  logic                       mem_we, mem_re;
  logic [NodeW-1:0]           mem_waddr, mem_raddr;
  logic [WordW-1:0]           mem_wdata;

  logic [VALUE_BITS-1:0]      rd_min, rd_max;
  logic [VALUE_BITS-1:0]      par_min, par_max;
  logic [PtrW-1:0]            hi_dec;
  logic [NodeW-1:0]           parent;
  logic                       q_err;

  assign rd_min = rdata_q[WordW-1:VALUE_BITS];
  assign rd_max = rdata_q[VALUE_BITS-1:0];

  // Combine the carried value with the word read back from memory.
  assign par_min = (rd_min < cur_min_q) ? rd_min : cur_min_q;
  assign par_max = (rd_max > cur_max_q) ? rd_max : cur_max_q;

  assign hi_dec = hi_q - PtrW'(1);
  assign parent = node_q >> 1;

  // A query is rejected for an empty range or a right bound at or past the element count or MAX_ELEMENTS.
  assign q_err = (in_i.payload.left_bound > in_i.payload.right_bound) ||
                 ({1'b0, in_i.payload.right_bound} >= count_q) ||
                 ({5'b0, in_i.payload.right_bound} >= MaxElem);

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid_q;
  assign out_o.payload.spread = out_spread_q;
  assign out_o.payload.status = out_status_q;

  // Sequencer for clearing, leaf-to-root updates and range walks.
  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    cur_min_d    = cur_min_q;
    cur_max_d    = cur_max_q;
    pend_d       = pend_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q;
    out_spread_d = out_spread_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = node_q;
    mem_raddr    = node_q;
    mem_wdata    = {cur_min_q, cur_max_q};

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {MinIdent, MaxIdent};
        node_d    = node_q + NodeW'(1);
        if (node_q == LastNode) begin
          node_d  = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.payload.func == rmmst_pkg::FUNC_WRITE) begin
            // Writes past the tree are dropped.
            if ({5'b0, in_i.payload.write_index} < MaxElem) begin
              node_d    = LeafNode + NodeW'(in_i.payload.write_index);
              cur_min_d = VALUE_BITS'(in_i.payload.write_value);
              cur_max_d = VALUE_BITS'(in_i.payload.write_value);
              state_d   = S_WLEAF;
            end
          end else begin
            err_d     = q_err;
            lo_d      = LeafPtr + PtrW'(in_i.payload.left_bound);
            hi_d      = LeafPtr + PtrW'(in_i.payload.right_bound) + PtrW'(1);
            cur_min_d = MinIdent;
            cur_max_d = MaxIdent;
            pend_d    = 1'b0;
            state_d   = q_err ? S_DONE : S_QWALK;
          end
        end
      end

      S_WLEAF: begin
        // Store the leaf and fetch its sibling.
        mem_we    = 1'b1;
        mem_waddr = node_q;
        mem_re    = 1'b1;
        mem_raddr = node_q ^ NodeW'(1);
        state_d   = S_WUP;
      end

      S_WUP: begin
        // Write the parent and, unless it is the root, fetch the parent's sibling in the same cycle.
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = {par_min, par_max};
        cur_min_d = par_min;
        cur_max_d = par_max;
        node_d    = parent;
        if (parent == RootNode) begin
          state_d = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent ^ NodeW'(1);
        end
      end

      S_QWALK: begin
        // Fold in the node read in the previous cycle.
        if (pend_q) begin
          cur_min_d = par_min;
          cur_max_d = par_max;
        end
        pend_d = 1'b0;
        if (lo_q < hi_q) begin
          if (lo_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = lo_q[NodeW-1:0];
            pend_d    = 1'b1;
            if (hi_q[0]) begin
              lo_d = lo_q + PtrW'(1);
            end else begin
              lo_d = (lo_q + PtrW'(1)) >> 1;
              hi_d = hi_q >> 1;
            end
          end else if (hi_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = hi_dec[NodeW-1:0];
            pend_d    = 1'b1;
            lo_d      = lo_q >> 1;
            hi_d      = hi_dec >> 1;
          end else begin
            lo_d = lo_q >> 1;
            hi_d = hi_q >> 1;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            out_spread_d = '0;
            out_status_d = rmmst_pkg::STATUS_ERR;
          end else begin
            out_status_d = rmmst_pkg::STATUS_OK;
            if (cur_max_q >= cur_min_q) begin
              out_spread_d = rmmst_pkg::ValW'(cur_max_q - cur_min_q);
            end else begin
              out_spread_d = '0;
            end
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
        node_d  = '0;
      end
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      node_q      <= '0;
      pend_q      <= 1'b0;
      err_q       <= 1'b0;
      count_q     <= rmmst_pkg::CountReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      pend_q      <= pend_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        count_q <= cfg_i.payload;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    cur_min_q    <= cur_min_d;
    cur_max_q    <= cur_max_d;
    out_spread_q <= out_spread_d;
    out_status_q <= out_status_d;
  end

  // Node memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= tree_mem[mem_raddr];
    end
  end

endmodule
